// ===== hw/rtl/wmmf_pkg.sv =====
package wmmf_pkg;

  // Default window depth and the widest count that any legal depth needs.
  localparam int WINDOW_DEPTH_DEFAULT = 20;
  localparam int WIN_CNT_W            = 7;

  // Item field widths.
  localparam int SPEED_W   = 16;
  localparam int THRESH_W  = 15;
  localparam int SMALL_W   = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 15;

  // Command codes carried in the command field.
  localparam logic CMD_VELOCITY = 1'b0;
  localparam logic CMD_TICK     = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TURN_THRESHOLD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_FILL        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATE_VOTES    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FORWARD_VOTES   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FORWARD_DROP    = 3'd5;

  // Register reset values.
  localparam logic [THRESH_W-1:0] TURN_THRESHOLD_RST  = 15'd1024;
  localparam logic [THRESH_W-1:0] DRIVE_THRESHOLD_RST = 15'd410;
  localparam logic [SMALL_W-1:0]  MIN_FILL_RST        = 5'd15;
  localparam logic [SMALL_W-1:0]  ROTATE_VOTES_RST    = 5'd15;
  localparam logic [SMALL_W-1:0]  FORWARD_VOTES_RST   = 5'd10;
  localparam logic [SMALL_W-1:0]  FORWARD_DROP_RST    = 5'd5;

  // Motion mode; the same codes serve as command classes.
  typedef enum logic [1:0] {
    MODE_STOP    = 2'd0,
    MODE_FORWARD = 2'd1,
    MODE_ROTATE  = 2'd2
  } mode_t;

  // Window control from the mode logic to the cell chain.
  typedef struct packed {
    logic               push;
    logic               is_rotate;
    logic               is_forward;
    logic               clear;
    logic               drop;
    logic [SMALL_W-1:0] drop_count;
  } win_ctrl_t;

  // Window status back to the mode logic.
  typedef struct packed {
    logic [WIN_CNT_W-1:0] fill;
    logic [WIN_CNT_W-1:0] rotate_count;
    logic [WIN_CNT_W-1:0] forward_count;
  } win_stat_t;

endpackage

// ===== hw/rtl/wmmf_if.sv =====
interface wmmf_item_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic signed [15:0] linear_x;
  logic signed [15:0] angular_z;

  modport source (output valid, command, linear_x, angular_z, input ready);
  modport sink (input valid, command, linear_x, angular_z, output ready);
endinterface

interface wmmf_result_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] sent_linear;
  logic signed [15:0] sent_angular;
  logic [1:0]  mode;

  modport source (output valid, sent_linear, sent_angular, mode, input ready);
  modport sink (input valid, sent_linear, sent_angular, mode, output ready);
endinterface

interface wmmf_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [14:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/wmmf_cell.sv =====
module wmmf_cell #(
  parameter int CNT_W = 5
) (
  input  logic             clk,
  input  logic             shift,
  input  logic [CNT_W-1:0] prev_rotate,
  input  logic [CNT_W-1:0] prev_forward,
  input  logic             add_rotate,
  input  logic             add_forward,
  output logic [CNT_W-1:0] rotate_sum,
  output logic [CNT_W-1:0] forward_sum
);

  // Each cell holds the class counts of the newest entries up to its own place.
  always_ff @(posedge clk) begin
    if (shift) begin
      rotate_sum  <= prev_rotate + CNT_W'(add_rotate);
      forward_sum <= prev_forward + CNT_W'(add_forward);
    end
  end

endmodule

// ===== hw/rtl/wmmf_window.sv =====
module wmmf_window #(
  parameter int WINDOW_DEPTH = wmmf_pkg::WINDOW_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  wmmf_pkg::win_ctrl_t ctrl,
  output wmmf_pkg::win_stat_t stat
);
  import wmmf_pkg::*;

  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int IDX_W = $clog2(WINDOW_DEPTH);

  logic [CNT_W-1:0] rotate_sum  [WINDOW_DEPTH];
  logic [CNT_W-1:0] forward_sum [WINDOW_DEPTH];
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] fill_next;
  logic [WIN_CNT_W-1:0] fill_wide;
  logic [WIN_CNT_W-1:0] drop_wide;
  logic [WIN_CNT_W-1:0] fill_left;
  logic [IDX_W-1:0] rd_idx;

  // Cell 0 holds the newest entry; cell i sums the i+1 newest classes.
  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    logic [CNT_W-1:0] prev_rotate;
    logic [CNT_W-1:0] prev_forward;
    if (i == 0) begin : g_head
      assign prev_rotate  = '0;
      assign prev_forward = '0;
    end else begin : g_body
      assign prev_rotate  = rotate_sum[i-1];
      assign prev_forward = forward_sum[i-1];
    end
    wmmf_cell #(.CNT_W(CNT_W)) u_cell (
      .clk         (clk),
      .shift       (ctrl.push),
      .prev_rotate (prev_rotate),
      .prev_forward(prev_forward),
      .add_rotate  (ctrl.is_rotate),
      .add_forward (ctrl.is_forward),
      .rotate_sum  (rotate_sum[i]),
      .forward_sum (forward_sum[i])
    );
  end

  assign fill_wide = WIN_CNT_W'(fill);
  assign drop_wide = WIN_CNT_W'(ctrl.drop_count);
  assign fill_left = fill_wide - drop_wide;

  always_comb begin
    fill_next = fill;
    if (ctrl.push) begin
      if (fill != CNT_W'(WINDOW_DEPTH)) begin
        fill_next = fill + CNT_W'(1);
      end
    end else if (ctrl.clear) begin
      fill_next = '0;
    end else if (ctrl.drop) begin
      if (drop_wide >= fill_wide) begin
        fill_next = '0;
      end else begin
        fill_next = fill_left[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

  // The counts of the whole window sit in the cell of the oldest valid entry.
  assign rd_idx = IDX_W'(fill - CNT_W'(1));

  always_comb begin
    stat.fill = fill_wide;
    if (fill == '0) begin
      stat.rotate_count  = '0;
      stat.forward_count = '0;
    end else begin
      stat.rotate_count  = WIN_CNT_W'(rotate_sum[rd_idx]);
      stat.forward_count = WIN_CNT_W'(forward_sum[rd_idx]);
    end
  end

endmodule

// ===== hw/rtl/windowed_motion_mode_filter_top.sv =====
// A tick's result is registered into the output register, or into the skid entry if that one is held.
// Throughput: one item per cycle while the skid entry is free, commands and ticks mixed freely;
// the cell chain and the fill count take each item as it comes; the vote read is a select at the fill count.
// A two-deep output stage keeps input flowing while a result waits to be taken.
// Reset (rst, synchronous): registers to defaults, fill zero, stop mode, latest command
// zero, output empty; the window cells themselves are not cleared.
module windowed_motion_mode_filter_top #(
  parameter int WINDOW_DEPTH = wmmf_pkg::WINDOW_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  wmmf_item_if.sink     item,
  wmmf_result_if.source result,
  wmmf_cfg_if.sink      cfg
);
  import wmmf_pkg::*;

  // Configuration registers.
  logic [THRESH_W-1:0] turn_threshold;
  logic [THRESH_W-1:0] drive_threshold;
  logic [SMALL_W-1:0]  min_fill;
  logic [SMALL_W-1:0]  rotate_votes;
  logic [SMALL_W-1:0]  forward_votes;
  logic [SMALL_W-1:0]  forward_drop;

  // Mode and latest command.
  mode_t               current_mode;
  mode_t               mode_next;
  logic [SPEED_W-1:0]  last_linear;
  logic [SPEED_W-1:0]  last_angular;

  // Output register and skid entry.
  logic                out_valid;
  logic [SPEED_W-1:0]  out_linear;
  logic [SPEED_W-1:0]  out_angular;
  mode_t               out_mode;
  logic                skid_valid;
  logic [SPEED_W-1:0]  skid_linear;
  logic [SPEED_W-1:0]  skid_angular;
  mode_t               skid_mode;

  logic                item_take;
  logic                is_tick;
  logic                is_command;
  logic [SPEED_W:0]    mag_linear;
  logic [SPEED_W:0]    mag_angular;
  logic                class_rotate;
  logic                class_forward;
  logic                may_change;
  win_ctrl_t           win_ctrl;
  win_stat_t           win_stat;
  logic [SPEED_W-1:0]  res_linear;
  logic [SPEED_W-1:0]  res_angular;
  logic                out_free;

  // The configuration port never stalls; writes past the register list are dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      turn_threshold  <= TURN_THRESHOLD_RST;
      drive_threshold <= DRIVE_THRESHOLD_RST;
      min_fill        <= MIN_FILL_RST;
      rotate_votes    <= ROTATE_VOTES_RST;
      forward_votes   <= FORWARD_VOTES_RST;
      forward_drop    <= FORWARD_DROP_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_TURN_THRESHOLD:  turn_threshold  <= cfg.data[THRESH_W-1:0];
        REG_DRIVE_THRESHOLD: drive_threshold <= cfg.data[THRESH_W-1:0];
        REG_MIN_FILL:        min_fill        <= cfg.data[SMALL_W-1:0];
        REG_ROTATE_VOTES:    rotate_votes    <= cfg.data[SMALL_W-1:0];
        REG_FORWARD_VOTES:   forward_votes   <= cfg.data[SMALL_W-1:0];
        REG_FORWARD_DROP:    forward_drop    <= cfg.data[SMALL_W-1:0];
        default: ;
      endcase
    end
  end

  // Input is taken whenever the skid entry is free, so a result waiting in the
  // output register does not hold up the next item.
  assign item.ready  = !skid_valid;
  assign item_take   = item.valid && item.ready;
  assign is_tick     = item_take && (item.command == CMD_TICK);
  assign is_command  = item_take && (item.command == CMD_VELOCITY);

  // Magnitudes are taken one bit wider so that the most negative value is exact.
  assign mag_angular = item.angular_z[SPEED_W-1]
                       ? (SPEED_W+1)'(-$signed({item.angular_z[SPEED_W-1], item.angular_z}))
                       : {1'b0, item.angular_z};
  assign mag_linear  = item.linear_x[SPEED_W-1]
                       ? (SPEED_W+1)'(-$signed({item.linear_x[SPEED_W-1], item.linear_x}))
                       : {1'b0, item.linear_x};

  // Rotate wins over forward when both thresholds are exceeded.
  assign class_rotate  = mag_angular > (SPEED_W+1)'(turn_threshold);
  assign class_forward = !class_rotate && (mag_linear > (SPEED_W+1)'(drive_threshold));

  wmmf_window #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_window (
    .clk (clk),
    .rst (rst),
    .ctrl(win_ctrl),
    .stat(win_stat)
  );

  // Mode vote. The mode may move only once the window holds min_fill entries.
  // Entering rotate or stop empties the window; entering forward drops the oldest
  // forward_drop entries; keeping the same mode leaves the window alone.
  assign may_change = win_stat.fill >= WIN_CNT_W'(min_fill);

  always_comb begin
    mode_next           = current_mode;
    win_ctrl.push       = is_command;
    win_ctrl.is_rotate  = class_rotate;
    win_ctrl.is_forward = class_forward;
    win_ctrl.clear      = 1'b0;
    win_ctrl.drop       = 1'b0;
    win_ctrl.drop_count = forward_drop;
    if (is_tick && may_change) begin
      if (win_stat.rotate_count > WIN_CNT_W'(rotate_votes)) begin
        mode_next      = MODE_ROTATE;
        win_ctrl.clear = (current_mode != MODE_ROTATE);
      end else if (win_stat.forward_count > WIN_CNT_W'(forward_votes)) begin
        mode_next      = MODE_FORWARD;
        win_ctrl.drop  = (current_mode != MODE_FORWARD);
      end else begin
        mode_next      = MODE_STOP;
        win_ctrl.clear = (current_mode != MODE_STOP);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_mode <= MODE_STOP;
      last_linear  <= '0;
      last_angular <= '0;
    end else begin
      current_mode <= mode_next;
      if (is_command) begin
        last_linear  <= item.linear_x;
        last_angular <= item.angular_z;
      end
    end
  end

  // The tick sends the latest command gated by the new mode.
  assign res_linear  = (mode_next == MODE_FORWARD) ? last_linear : '0;
  assign res_angular = (mode_next == MODE_ROTATE) ? last_angular : '0;

  // Output register with a skid entry behind it.
  assign out_free = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= is_tick;
      end
    end else if (is_tick) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_linear  <= skid_linear;
        out_angular <= skid_angular;
        out_mode    <= skid_mode;
      end else begin
        out_linear  <= res_linear;
        out_angular <= res_angular;
        out_mode    <= mode_next;
      end
    end else if (is_tick) begin
      skid_linear  <= res_linear;
      skid_angular <= res_angular;
      skid_mode    <= mode_next;
    end
  end

  assign result.valid        = out_valid;
  assign result.sent_linear  = out_linear;
  assign result.sent_angular = out_angular;
  assign result.mode         = out_mode;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the windowed motion-mode filter.
// A short table of directed items comes first. After it come phases of random items, each
// phase under its own register setting. Every accepted item is fed to a predictor in this
// file, and every accepted result is compared with the oldest prediction.
module tb_top;
  import wmmf_pkg::*;

  localparam int WINDOW_DEPTH = WINDOW_DEPTH_DEFAULT;
  localparam int RESET_CYCLES = 6;
  // The block registers a tick's result as it takes the tick. The pad covers an
  // item that makes no result but is still being absorbed.
  localparam int LATENCY_PAD  = 4;
  localparam int HOLD_CYCLES  = 150;
  localparam int QUIET_LIMIT  = 3000;
  localparam int PHASES       = 18;
  localparam int PHASE_ITEMS  = 75;
  // The first index past the register list. Writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_PAST_LIST = REG_FORWARD_DROP + 3'd1;

  // One gated command as the block should send it.
  typedef struct {
    logic signed [SPEED_W-1:0] lin;
    logic signed [SPEED_W-1:0] ang;
    mode_t                     mode;
  } gated_cmd_t;

  // Travels with each offered item. A typed row carries its own answer.
  typedef struct {
    bit         typed;
    gated_cmd_t want;
  } tick_note_t;

  // One row of the directed table: either a register write or an item.
  typedef struct {
    bit                        is_cfg;
    logic [CFG_IDX_W-1:0]      idx;
    logic [CFG_DAT_W-1:0]      data;
    logic                      cmd;
    logic signed [SPEED_W-1:0] lin;
    logic signed [SPEED_W-1:0] ang;
    bit                        typed;
    gated_cmd_t                want;
  } dir_row_t;

  logic clk;
  logic rst;

  wmmf_item_if   item_ch ();
  wmmf_result_if res_ch ();
  wmmf_cfg_if    cfg_ch ();

  windowed_motion_mode_filter_top DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  // The predictor's own copy of the registers and of the filter state.
  logic [THRESH_W-1:0]       thr_turn;
  logic [THRESH_W-1:0]       thr_drive;
  logic [SMALL_W-1:0]        fill_need;
  logic [SMALL_W-1:0]        rot_need;
  logic [SMALL_W-1:0]        fwd_need;
  logic [SMALL_W-1:0]        fwd_drop;
  mode_t                     vote_hist[$];
  mode_t                     cur_mode;
  logic signed [SPEED_W-1:0] last_lin;
  logic signed [SPEED_W-1:0] last_ang;

  gated_cmd_t gated_q[$];
  tick_note_t tick_note_q[$];

  int  mismatches;
  int  results_seen;
  int  items_taken;
  int  ticks_taken;
  int  cfg_writes;
  int  quiet;
  bit  gaps_on;
  int  holdoffs_asked;
  int  holdoffs_served;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Classes a velocity command. The magnitude is taken in a wider type, so the most
  // negative input counts as 32768 and clears every threshold.
  function automatic mode_t sort_cmd(logic signed [SPEED_W-1:0] lin,
                                     logic signed [SPEED_W-1:0] ang);
    int mag_lin;
    int mag_ang;
    mag_lin = (lin < 0) ? -int'(lin) : int'(lin);
    mag_ang = (ang < 0) ? -int'(ang) : int'(ang);
    if (mag_ang > int'(thr_turn)) return MODE_ROTATE;
    if (mag_lin > int'(thr_drive)) return MODE_FORWARD;
    return MODE_STOP;
  endfunction

  // Advances the filter by one item. Returns 1 and the gated command on a tick.
  function automatic bit filter_item(input logic cmd, input logic signed [SPEED_W-1:0] lin,
                                     input logic signed [SPEED_W-1:0] ang,
                                     output gated_cmd_t outc);
    int rot_cnt;
    int fwd_cnt;
    rot_cnt = 0;
    fwd_cnt = 0;
    outc.lin = '0;
    outc.ang = '0;
    outc.mode = cur_mode;
    if (cmd == CMD_VELOCITY) begin
      // A full window loses its oldest class to make room.
      if (vote_hist.size() >= WINDOW_DEPTH) void'(vote_hist.pop_front());
      vote_hist.insert(vote_hist.size(), sort_cmd(lin, ang));
      last_lin = lin;
      last_ang = ang;
      return 1'b0;
    end
    foreach (vote_hist[i]) begin
      if (vote_hist[i] == MODE_ROTATE) rot_cnt++;
      else if (vote_hist[i] == MODE_FORWARD) fwd_cnt++;
    end
    // Rotate wins over forward. Staying in the same mode leaves the window alone.
    if (vote_hist.size() >= int'(fill_need)) begin
      if (rot_cnt > int'(rot_need)) begin
        if (cur_mode != MODE_ROTATE) vote_hist.delete();
        cur_mode = MODE_ROTATE;
      end else if (fwd_cnt > int'(fwd_need)) begin
        // Dropping more than the window holds simply empties it.
        if (cur_mode != MODE_FORWARD) begin
          repeat (int'(fwd_drop)) if (vote_hist.size() != 0) void'(vote_hist.pop_front());
        end
        cur_mode = MODE_FORWARD;
      end else begin
        if (cur_mode != MODE_STOP) vote_hist.delete();
        cur_mode = MODE_STOP;
      end
    end
    outc.lin = (cur_mode == MODE_FORWARD) ? last_lin : '0;
    outc.ang = (cur_mode == MODE_ROTATE) ? last_ang : '0;
    outc.mode = cur_mode;
    return 1'b1;
  endfunction

  // A signed speed whose magnitude lies in [lo, hi]. A magnitude of 32768 exists only
  // as the most negative value.
  function automatic logic signed [SPEED_W-1:0] pick_speed(int lo, int hi);
    int mag;
    mag = int'($urandom_range(hi, lo));
    if (mag == 32768) return 16'sh8000;
    if ($urandom_range(0, 1) == 1) return SPEED_W'(-mag);
    return SPEED_W'(mag);
  endfunction

  // All three handshakes are sampled here, at the clock edge, on values that settled
  // before it. The result is checked first, so a tick taken at the same edge only queues
  // behind older expectations. The idle-cycle count for the watchdog is kept here too.
  always @(posedge clk) begin : monitor
    gated_cmd_t want;
    gated_cmd_t pred;
    tick_note_t note;
    bit         any_taken;
    any_taken = 1'b0;
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) begin
        any_taken = 1'b1;
        if (gated_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with no tick pending: lin %0d ang %0d mode %0d",
                   $time, res_ch.sent_linear, res_ch.sent_angular, res_ch.mode);
        end else begin
          want = gated_q.pop_front();
          results_seen++;
          if ({res_ch.sent_linear, res_ch.sent_angular, res_ch.mode} !==
              {want.lin, want.ang, want.mode}) begin
            mismatches++;
            $display("%0t: expected lin %0d ang %0d mode %0d, got lin %0d ang %0d mode %0d",
                     $time, want.lin, want.ang, want.mode,
                     res_ch.sent_linear, res_ch.sent_angular, res_ch.mode);
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        any_taken = 1'b1;
        cfg_writes++;
        case (cfg_ch.index)
          REG_TURN_THRESHOLD:  thr_turn  = cfg_ch.data;
          REG_DRIVE_THRESHOLD: thr_drive = cfg_ch.data;
          REG_MIN_FILL:        fill_need = cfg_ch.data[SMALL_W-1:0];
          REG_ROTATE_VOTES:    rot_need  = cfg_ch.data[SMALL_W-1:0];
          REG_FORWARD_VOTES:   fwd_need  = cfg_ch.data[SMALL_W-1:0];
          REG_FORWARD_DROP:    fwd_drop  = cfg_ch.data[SMALL_W-1:0];
          default: ;
        endcase
      end
      if (item_ch.valid && item_ch.ready) begin
        any_taken = 1'b1;
        items_taken++;
        note = tick_note_q.pop_front();
        if (filter_item(item_ch.command, item_ch.linear_x, item_ch.angular_z, pred)) begin
          ticks_taken++;
          gated_q.insert(gated_q.size(), note.typed ? note.want : pred);
        end
      end
    end
    quiet <= any_taken ? 0 : quiet + 1;
  end

  // Result side. Ready drops at random while gaps are on. On request it stays low for a
  // long stretch, so the output stage fills and the input has to stall behind it.
  initial begin : receiver
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (holdoffs_asked != holdoffs_served) begin
        holdoffs_served++;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        res_ch.ready <= !(gaps_on && $urandom_range(0, 99) < 28);
      end
    end
  end

  // Ends the run if nothing at all moves for too long.
  initial begin : watchdog
    while (quiet < QUIET_LIMIT) @(posedge clk);
    $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // Offers one item and returns at the edge that takes it. Valid is not lowered on the
  // way out, so a following item can go out at once without a glitch.
  task automatic send_item(logic cmd, logic signed [SPEED_W-1:0] lin,
                           logic signed [SPEED_W-1:0] ang, bit typed, gated_cmd_t want);
    tick_note_t note;
    while (gaps_on && $urandom_range(0, 99) < 28) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    note.typed = typed;
    note.want = want;
    tick_note_q.insert(tick_note_q.size(), note);
    item_ch.valid     <= 1'b1;
    item_ch.command   <= cmd;
    item_ch.linear_x  <= lin;
    item_ch.angular_z <= ang;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  // Stops offering items until every tick has been answered, then waits out pad cycles.
  task automatic drain(int pad);
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (gated_q.size() != 0) @(posedge clk);
    repeat (pad) @(posedge clk);
  endtask

  // Registers change only on an idle block.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    drain(LATENCY_PAD);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Writes all six registers. With junk set, the bits above a 5-bit field are filled at
  // random to show that only the low bits count. Sometimes an index past the list is hit.
  task automatic apply_setting(int tt, int dt, int mf, int rv, int fv, int fd, bit junk);
    int                   vals[4];
    logic [CFG_IDX_W-1:0] idxs[4];
    logic [CFG_DAT_W-1:0] d;
    vals = '{mf, rv, fv, fd};
    idxs = '{REG_MIN_FILL, REG_ROTATE_VOTES, REG_FORWARD_VOTES, REG_FORWARD_DROP};
    write_reg(REG_TURN_THRESHOLD, CFG_DAT_W'(tt));
    write_reg(REG_DRIVE_THRESHOLD, CFG_DAT_W'(dt));
    for (int i = 0; i < 4; i++) begin
      d = CFG_DAT_W'(vals[i]) & 15'h001F;
      if (junk) d[CFG_DAT_W-1:SMALL_W] = 10'($urandom_range(0, 1023));
      write_reg(idxs[i], d);
    end
    if ($urandom_range(0, 2) == 0)
      write_reg(REG_PAST_LIST + CFG_IDX_W'($urandom_range(0, 1)), 15'($urandom));
  endtask

  // Builds a velocity command of the wanted class under the current thresholds.
  task automatic make_cmd(int cls, output logic signed [SPEED_W-1:0] lin,
                          output logic signed [SPEED_W-1:0] ang);
    case (cls)
      MODE_ROTATE: begin
        ang = pick_speed(int'(thr_turn) + 1, 32768);
        lin = 16'($urandom);
      end
      MODE_FORWARD: begin
        ang = pick_speed(0, int'(thr_turn));
        lin = pick_speed(int'(thr_drive) + 1, 32768);
      end
      default: begin
        ang = pick_speed(0, int'(thr_turn));
        lin = pick_speed(0, int'(thr_drive));
      end
    endcase
  endtask

  // One phase of random items. Most of it is bursts of commands that lean toward one
  // class, followed by a few ticks, so the votes actually reach the thresholds and the
  // mode moves. The rest is noise with fully random fields.
  task automatic run_phase(int n, bit mid_drain);
    int                        left;
    int                        target;
    int                        cls;
    int                        len;
    logic signed [SPEED_W-1:0] lin;
    logic signed [SPEED_W-1:0] ang;
    gated_cmd_t                none;
    none = '{default: '0, mode: MODE_STOP};
    left = n;
    while (left > 0) begin
      if (mid_drain && left <= n / 2) begin
        drain(0);
        mid_drain = 1'b0;
      end
      if ($urandom_range(0, 99) < 72) begin
        target = $urandom_range(0, 2);
        len = $urandom_range(1, WINDOW_DEPTH + 4);
        for (int i = 0; i < len && left > 0; i++) begin
          cls = ($urandom_range(0, 99) < 85) ? target : int'($urandom_range(0, 2));
          make_cmd(cls, lin, ang);
          send_item(CMD_VELOCITY, lin, ang, 1'b0, none);
          left--;
        end
        repeat ($urandom_range(1, 3)) begin
          send_item(CMD_TICK, 16'($urandom), 16'($urandom), 1'b0, none);
          left--;
        end
      end else begin
        send_item(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom), 1'b0, none);
        left--;
      end
    end
  endtask

  // A threshold drawn mostly from the working range, sometimes anywhere or at an end.
  function automatic int pick_thr();
    case ($urandom_range(0, 3))
      0:       return int'($urandom_range(0, 32767));
      1:       return ($urandom_range(0, 1) == 1) ? 32767 : 0;
      default: return int'($urandom_range(0, 4096));
    endcase
  endfunction

  // A 5-bit setting: mostly within the window depth, now and then anywhere in the field.
  function automatic int pick_small(int lo);
    if ($urandom_range(0, 99) < 15) return int'($urandom_range(0, 31));
    return int'($urandom_range(lo, WINDOW_DEPTH));
  endfunction

  initial begin : stimulus
    dir_row_t   rows[$];
    dir_row_t   row;
    gated_cmd_t none;
    none = '{default: '0, mode: MODE_STOP};

    // Every input is at a known value from time zero, with reset held.
    rst = 1'b1;
    gaps_on = 1'b1;
    quiet = 0;
    holdoffs_asked = 0;
    holdoffs_served = 0;
    mismatches = 0;
    results_seen = 0;
    items_taken = 0;
    ticks_taken = 0;
    cfg_writes = 0;
    item_ch.valid = 1'b0;
    item_ch.command = CMD_VELOCITY;
    item_ch.linear_x = '0;
    item_ch.angular_z = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_TURN_THRESHOLD;
    cfg_ch.data = '0;

    // The predictor starts from the reset state.
    thr_turn = TURN_THRESHOLD_RST;
    thr_drive = DRIVE_THRESHOLD_RST;
    fill_need = MIN_FILL_RST;
    rot_need = ROTATE_VOTES_RST;
    fwd_need = FORWARD_VOTES_RST;
    fwd_drop = FORWARD_DROP_RST;
    vote_hist.delete();
    cur_mode = MODE_STOP;
    last_lin = '0;
    last_ang = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table. Rows with a typed answer are the ones whose result is plain to see.
    // The others are left to the predictor.
    row = '{default: '0, want: none};
    // A tick straight after reset sends zeros in stop mode.
    row.cmd = CMD_TICK; row.lin = 16'sh7FFF; row.ang = -16'sd1;
    row.typed = 1'b1; row.want = '{16'sd0, 16'sd0, MODE_STOP};
    rows.insert(rows.size(), row);
    // The most negative angular rate counts as rotate.
    row = '{default: '0, want: none};
    row.cmd = CMD_VELOCITY; row.lin = 16'sh7FFF; row.ang = 16'sh8000;
    rows.insert(rows.size(), row);
    // One entry is well below the fill that is needed, so the mode holds.
    row = '{default: '0, want: none};
    row.cmd = CMD_TICK; row.typed = 1'b1; row.want = '{16'sd0, 16'sd0, MODE_STOP};
    rows.insert(rows.size(), row);
    // With no fill needed and no rotate votes to beat, that single entry turns the mode.
    row = '{default: '0, want: none};
    row.is_cfg = 1'b1; row.idx = REG_MIN_FILL; row.data = 15'd0;
    rows.insert(rows.size(), row);
    row.idx = REG_ROTATE_VOTES; row.data = 15'd0;
    rows.insert(rows.size(), row);
    row = '{default: '0, want: none};
    row.cmd = CMD_TICK; row.typed = 1'b1; row.want = '{16'sd0, 16'sh8000, MODE_ROTATE};
    rows.insert(rows.size(), row);
    // Entering rotate emptied the window, so the next tick falls back to stop.
    row.want = '{16'sd0, 16'sd0, MODE_STOP};
    rows.insert(rows.size(), row);
    // The drop count is written with junk in its upper bits and must read as two.
    row = '{default: '0, want: none};
    row.is_cfg = 1'b1; row.idx = REG_FORWARD_VOTES; row.data = 15'd0;
    rows.insert(rows.size(), row);
    row.idx = REG_FORWARD_DROP; row.data = 15'h7FE2;
    rows.insert(rows.size(), row);
    // Threshold edges: exactly at a threshold is not above it.
    row = '{default: '0, want: none};
    row.cmd = CMD_VELOCITY; row.lin = 16'sh8000; row.ang = 16'sd0;
    rows.insert(rows.size(), row);
    row.lin = 16'sd411; row.ang = 16'sd1024;
    rows.insert(rows.size(), row);
    row.lin = 16'sd410; row.ang = -16'sd1024;
    rows.insert(rows.size(), row);
    // Two forward votes win. Entering forward drops the two oldest, leaving one stop entry.
    row = '{default: '0, want: none};
    row.cmd = CMD_TICK; row.typed = 1'b1; row.want = '{16'sd410, 16'sd0, MODE_FORWARD};
    rows.insert(rows.size(), row);
    row.want = '{16'sd0, 16'sd0, MODE_STOP};
    rows.insert(rows.size(), row);
    // Writes past the register list change nothing.
    row = '{default: '0, want: none};
    row.is_cfg = 1'b1; row.idx = REG_PAST_LIST; row.data = 15'h7FFF;
    rows.insert(rows.size(), row);
    row.idx = REG_PAST_LIST + 3'd1; row.data = 15'h0000;
    rows.insert(rows.size(), row);
    // Thresholds at both ends of their range.
    row.idx = REG_TURN_THRESHOLD; row.data = 15'd0;
    rows.insert(rows.size(), row);
    row.idx = REG_DRIVE_THRESHOLD; row.data = 15'h7FFF;
    rows.insert(rows.size(), row);
    row = '{default: '0, want: none};
    row.cmd = CMD_VELOCITY; row.lin = 16'sh7FFF; row.ang = 16'sd1;
    rows.insert(rows.size(), row);
    row.lin = 16'sh8000; row.ang = 16'sd0;
    rows.insert(rows.size(), row);
    row.cmd = CMD_TICK; row.lin = 16'sh5555; row.ang = 16'shAAAA;
    rows.insert(rows.size(), row);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) write_reg(rows[i].idx, rows[i].data);
      else send_item(rows[i].cmd, rows[i].lin, rows[i].ang, rows[i].typed, rows[i].want);
    end

    // Random phases. The first few use fixed settings: defaults, all at the top, all at
    // zero, a fill need beyond the window, and loose votes with a large drop. The rest
    // are drawn at random. One phase runs with no gaps at all; two carry a long result
    // hold-off and one pauses the input halfway until all results are in.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: apply_setting(1024, 410, 15, 15, 10, 5, 1'b0);
        1: apply_setting(32767, 32767, 20, 20, 20, 20, 1'b1);
        2: apply_setting(0, 0, 0, 0, 0, 0, 1'b0);
        3: apply_setting(1024, 410, 31, 15, 10, 5, 1'b1);
        4: apply_setting(2048, 600, 1, 0, 0, 31, 1'b0);
        5: apply_setting(1024, 410, 20, 19, 19, 20, 1'b0);
        default: apply_setting(pick_thr(), pick_thr(), pick_small(1), pick_small(0),
                               pick_small(0), pick_small(0), $urandom_range(0, 1) == 1);
      endcase
      gaps_on = (p != 4);
      if (p == 0 || p == 9) holdoffs_asked++;
      run_phase(PHASE_ITEMS, p == 6);
    end

    // Let the last results come out, then a few more cycles for anything stray.
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (gated_q.size() != 0) @(posedge clk);
    repeat (2 * LATENCY_PAD) @(posedge clk);
    if (gated_q.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected results never arrived", $time, gated_q.size());
    end

    $display("Run covered %0d items with %0d ticks and %0d checked results,",
             items_taken, ticks_taken, results_seen);
    $display("under %0d register writes across %0d settings; %0d mismatches.",
             cfg_writes, PHASES + 1, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
